/* src/csm_pkg.sv */
// Shared types, constants and helper functions for the circle span mask rasterizer.
`timescale 1ns / 1ps

package csm_pkg;

  localparam int COLUMNS             = 40;
  localparam int LINES_PER_FRAME_DEF = 192;
  localparam int METRIC_W            = 19;
  localparam int RADIUS_W            = 18;

  localparam logic [5:0] CENTER_COLUMN_RST = 6'd19;
  localparam logic [7:0] CENTER_ROW_RST    = 8'd100;

  // Input item opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_LINE  = 1'b1;

  // Configuration register indexes
  localparam logic REG_CENTER_COLUMN = 1'b0;
  localparam logic REG_CENTER_ROW    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DY,
    S_L_MUL,
    S_L_CHK,
    S_R_MUL,
    S_R_CHK,
    S_DONE
  } csm_state_t;

  // Request into the shared squaring unit
  typedef struct packed {
    logic       go;
    logic       is_dy;
    logic [7:0] mag;
  } metric_req_t;

  // Sequencer status toward the channel logic
  typedef struct packed {
    logic busy;
    logic load_out;
    logic last_line;
  } ctrl_sts_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  // Pack 20 mask bits into the three playfield registers of one screen half,
  // ANDed with the existing bytes. Result is {pf2, pf1, pf0}.
  function automatic logic [23:0] pack_half(input logic [19:0] m,
                                            input logic [7:0]  o0,
                                            input logic [7:0]  o1,
                                            input logic [7:0]  o2);
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    p0 = o0 & {m[3:0], 4'b0000};
    p1 = o1 & rev8(m[11:4]);
    p2 = o2 & m[19:12];
    return {p2, p1, p0};
  endfunction

endpackage

/* src/csm_metric.sv */
// Shared squaring unit: squares a magnitude, keeps dy^2, forms 49*dx^2 + dy^2.
`timescale 1ns / 1ps

module csm_metric import csm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  metric_req_t         req,
  output logic [METRIC_W-1:0] metric
);

  logic [15:0] prod_r;
  logic [15:0] prod_nxt;
  logic        is_dy_r;
  logic [15:0] dy2_r;
  logic [21:0] wide;

  assign prod_nxt = {8'b0, req.mag} * {8'b0, req.mag};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_dy_r <= 1'b0;
    end else begin
      is_dy_r <= req.go & req.is_dy;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      prod_r <= prod_nxt;
    end
    // keep the row term for the whole scanline
    if (is_dy_r) begin
      dy2_r <= prod_r;
    end
  end

  // 49 * dx^2 as shift-add, then add the row term
  assign wide   = ({6'b0, prod_r} << 5) + ({6'b0, prod_r} << 4) + {6'b0, prod_r}
                  + {6'b0, dy2_r};
  assign metric = wide[METRIC_W-1:0];

endmodule

/* src/csm_ctrl.sv */
// Scanline sequencer: edge stepping, mask bits, line counter.
`timescale 1ns / 1ps

module csm_ctrl import csm_pkg::*; #(
  parameter int LINES_PER_FRAME = LINES_PER_FRAME_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_go,
  input  logic                line_go,
  input  logic [5:0]          left_start,
  input  logic [5:0]          right_start,
  input  logic [RADIUS_W-1:0] radius_squared,
  input  logic [5:0]          center_column,
  input  logic [7:0]          center_row,
  input  logic                out_free,
  input  logic [METRIC_W-1:0] metric,
  output metric_req_t         req,
  output ctrl_sts_t           sts,
  output logic [COLUMNS-1:0]  mask
);

  localparam logic [7:0] LAST_LINE = 8'(LINES_PER_FRAME - 1);
  localparam logic signed [7:0] COL_END = 8'(COLUMNS);

  csm_state_t state_r, state_nxt;

  logic signed [6:0]   left_r, left_nxt;
  logic signed [6:0]   right_r, right_nxt;
  logic [RADIUS_W-1:0] r2_r, r2_nxt;
  logic [7:0]          line_r, line_nxt;
  logic [COLUMNS-1:0]  mask_r, mask_nxt;
  logic                grow_r, grow_nxt;

  logic signed [7:0] cc_s;
  logic signed [7:0] l_s;
  logic signed [7:0] r_s;
  logic signed [7:0] dx;
  logic        [7:0] dx_mag;
  logic signed [8:0] dy;
  logic        [7:0] dy_mag;
  logic              in_circ;
  logic              outside;
  logic              l_cont;
  logic              r_cont;
  logic              l_sat;

  assign cc_s = signed'({2'b00, center_column});
  assign l_s  = {left_r[6], left_r};
  assign r_s  = {right_r[6], right_r};

  assign dx     = (state_r == S_R_MUL) ? (cc_s - r_s) : (cc_s - l_s);
  assign dx_mag = dx[7] ? 8'(-dx) : 8'(dx);
  assign dy     = signed'({1'b0, center_row}) - signed'({1'b0, line_r});
  assign dy_mag = dy[8] ? 8'(-dy) : 8'(dy);

  assign in_circ = metric < {1'b0, r2_r};
  assign outside = metric > {1'b0, r2_r};

  assign l_cont = grow_r ? (in_circ && l_s >= 8'sd0  && l_s <= cc_s)
                         : (outside && l_s >= -8'sd1 && l_s <= cc_s);
  assign r_cont = grow_r ? (in_circ && r_s <  COL_END && r_s >= cc_s)
                         : (outside && r_s <= COL_END && r_s >= cc_s);
  assign l_sat  = !grow_r && (l_s == 8'sd63);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (line_go) state_nxt = S_DY;
      S_DY:    state_nxt = S_L_MUL;
      S_L_MUL: state_nxt = S_L_CHK;
      S_L_CHK: state_nxt = (l_cont && !l_sat) ? S_L_MUL : S_R_MUL;
      S_R_MUL: state_nxt = S_R_CHK;
      S_R_CHK: state_nxt = r_cont ? S_R_MUL : S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req.go         = 1'b0;
    req.is_dy      = 1'b0;
    req.mag        = dx_mag;
    sts.busy       = (state_r != S_IDLE);
    sts.load_out   = 1'b0;
    sts.last_line  = (line_r == LAST_LINE);
    case (state_r)
      S_DY: begin
        req.go    = 1'b1;
        req.is_dy = 1'b1;
        req.mag   = dy_mag;
      end
      S_L_MUL, S_R_MUL: begin
        req.go = 1'b1;
      end
      S_DONE: begin
        sts.load_out = out_free;
      end
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    r2_nxt    = r2_r;
    line_nxt  = line_r;
    mask_nxt  = mask_r;
    grow_nxt  = grow_r;
    case (state_r)
      S_IDLE: begin
        if (start_go) begin
          left_nxt  = signed'({1'b0, left_start});
          right_nxt = signed'({1'b0, right_start});
          r2_nxt    = radius_squared;
          line_nxt  = '0;
        end else if (line_go) begin
          grow_nxt = (line_r <= center_row);
        end
      end
      S_L_CHK: begin
        if (l_cont) begin
          // columns off the playfield are dropped
          if (l_s >= 8'sd0 && l_s < COL_END) begin
            mask_nxt[l_s[5:0]] = grow_r;
          end
          if (grow_r) begin
            left_nxt = left_r - 7'sd1;
          end else if (!l_sat) begin
            left_nxt = left_r + 7'sd1;
          end
        end
      end
      S_R_CHK: begin
        if (r_cont) begin
          if (r_s >= 8'sd0 && r_s < COL_END) begin
            mask_nxt[r_s[5:0]] = grow_r;
          end
          right_nxt = grow_r ? (right_r + 7'sd1) : (right_r - 7'sd1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          line_nxt = line_r + 8'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      left_r  <= '0;
      right_r <= '0;
      r2_r    <= '0;
      line_r  <= '0;
      mask_r  <= '0;
      grow_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      r2_r    <= r2_nxt;
      line_r  <= line_nxt;
      mask_r  <= mask_nxt;
      grow_r  <= grow_nxt;
    end
  end

  assign mask = mask_r;

endmodule

/* src/circle_span_mask_raster.sv */
// Top level of the circle span mask rasterizer: channels, configuration, result register.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_stall    | op, edges, radius, six old bytes
//   out_    | output    | out_valid / out_stall  | six new bytes, last_line
//   cfg_    | input     | cfg_we                 | cfg_index, cfg_wdata
//
// A scanline transaction steps each edge column by column; every step costs a
// square and a compare on the one shared multiplier.
// A stalled result register holds the sequencer in its final state.
// Synchronous reset clears the mask and edges at once; no clearing pass.
`timescale 1ns / 1ps

module circle_span_mask_raster import csm_pkg::*; #(
  parameter int LINES_PER_FRAME = LINES_PER_FRAME_DEF
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic [5:0]          in_left_start,
  input  logic [5:0]          in_right_start,
  input  logic [RADIUS_W-1:0] in_radius_squared,
  input  logic [7:0]          in_old_left_pf0,
  input  logic [7:0]          in_old_left_pf1,
  input  logic [7:0]          in_old_left_pf2,
  input  logic [7:0]          in_old_right_pf0,
  input  logic [7:0]          in_old_right_pf1,
  input  logic [7:0]          in_old_right_pf2,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_new_left_pf0,
  output logic [7:0]          out_new_left_pf1,
  output logic [7:0]          out_new_left_pf2,
  output logic [7:0]          out_new_right_pf0,
  output logic [7:0]          out_new_right_pf1,
  output logic [7:0]          out_new_right_pf2,
  output logic                out_last_line
);

  logic [5:0] center_column_r;
  logic [7:0] center_row_r;

  logic [7:0] old_r [6];
  logic [23:0] left_pack;
  logic [23:0] right_pack;

  logic                out_valid_r;
  logic [47:0]         out_data_r;
  logic                out_last_r;

  logic                in_accept;
  logic                out_free;
  metric_req_t         req;
  ctrl_sts_t           sts;
  logic [METRIC_W-1:0] metric;
  logic [COLUMNS-1:0]  mask;

  assign in_stall  = sts.busy;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_column_r <= CENTER_COLUMN_RST;
      center_row_r    <= CENTER_ROW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_COLUMN: center_column_r <= cfg_wdata[5:0];
        REG_CENTER_ROW:    center_row_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold the scanline's bytes until the result is packed
  always_ff @(posedge clk) begin
    if (in_accept && in_op == OP_LINE) begin
      old_r[0] <= in_old_left_pf0;
      old_r[1] <= in_old_left_pf1;
      old_r[2] <= in_old_left_pf2;
      old_r[3] <= in_old_right_pf0;
      old_r[4] <= in_old_right_pf1;
      old_r[5] <= in_old_right_pf2;
    end
  end

  csm_metric u_metric (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .metric (metric)
  );

  csm_ctrl #(
    .LINES_PER_FRAME (LINES_PER_FRAME)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start_go       (in_accept && in_op == OP_START),
    .line_go        (in_accept && in_op == OP_LINE),
    .left_start     (in_left_start),
    .right_start    (in_right_start),
    .radius_squared (in_radius_squared),
    .center_column  (center_column_r),
    .center_row     (center_row_r),
    .out_free       (out_free),
    .metric         (metric),
    .req            (req),
    .sts            (sts),
    .mask           (mask)
  );

  assign left_pack  = pack_half(mask[19:0], old_r[0], old_r[1], old_r[2]);
  assign right_pack = pack_half(mask[39:20], old_r[3], old_r[4], old_r[5]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sts.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.load_out) begin
      out_data_r <= {right_pack, left_pack};
      out_last_r <= sts.last_line;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_new_left_pf0  = out_data_r[7:0];
  assign out_new_left_pf1  = out_data_r[15:8];
  assign out_new_left_pf2  = out_data_r[23:16];
  assign out_new_right_pf0 = out_data_r[31:24];
  assign out_new_right_pf1 = out_data_r[39:32];
  assign out_new_right_pf2 = out_data_r[47:40];
  assign out_last_line     = out_last_r;

  // A result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    sts.load_out |-> out_free)
    else $error("result loaded over a pending transaction");

  // The sequencer only starts working on an accepted scanline transaction
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sts.busy) |-> $past(in_accept && in_op == OP_LINE))
    else $error("sequencer started without a scanline transaction");

  // A new result appears only after the sequencer finished a scanline
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(sts.busy))
    else $error("result appeared without scanline work");

endmodule
